>>> rtl/core/ut_pkg.sv
// Shared types and constants for the unicode transcoder.
// Encoding codes, code point limits, UTF-8 lead masks, decoder status struct.
// No dependencies.
package ut_pkg;

    localparam int CP_W  = 32;
    localparam int CFG_W = 4;

    typedef enum logic [CFG_W-1:0] {
        ENC_ASCII   = 4'd0,
        ENC_LATIN1  = 4'd1,
        ENC_UTF8    = 4'd2,
        ENC_UTF16BE = 4'd3,
        ENC_UTF16LE = 4'd4,
        ENC_UTF32BE = 4'd5,
        ENC_UTF32LE = 4'd6,
        ENC_UCS2    = 4'd7,
        ENC_UCS4    = 4'd8
    } t_enc;

    // register indexes on the config port
    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_TGT = 1'b1;

    localparam logic [CP_W-1:0] CP_REPL      = 32'h0000_FFFD;
    localparam logic [CP_W-1:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [CP_W-1:0] CP_BMP_MAX   = 32'h0000_FFFF;
    localparam logic [CP_W-1:0] CP_UCS4_MAX  = 32'h7FFF_FFFF;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 32'h0001_0000;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;

    localparam logic [7:0] UTF8_L2_MASK = 8'hE0;
    localparam logic [7:0] UTF8_L2      = 8'hC0;
    localparam logic [7:0] UTF8_L3_MASK = 8'hF0;
    localparam logic [7:0] UTF8_L3      = 8'hE0;
    localparam logic [7:0] ASCII_QMARK  = 8'h3F;

    typedef struct packed {
        logic sur_pending;
        logic utf8_busy;
    } t_dec_stat;

endpackage

>>> rtl/core/ut_in_if.sv
// Input byte channel: valid/ready handshake with source byte and end flag.
// No dependencies.
interface ut_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

>>> rtl/core/ut_out_if.sv
// Output byte channel: valid/ready handshake with encoded byte and char flag.
// No dependencies.
interface ut_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       char_done;

    modport source (output valid, output out_byte, output char_done, input ready);
    modport sink   (input valid, input out_byte, input char_done, output ready);
endinterface

>>> rtl/core/ut_decode.sv
// Source side: gathers bytes into units and surrogate pairs, yields code points.
// Depends on ut_pkg.
module ut_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_clr,
    input  logic [ut_pkg::CFG_W-1:0]     i_src,
    input  logic [7:0]                   i_byte,
    input  logic                         i_eos,
    output logic                         o_emit,
    output logic [ut_pkg::CP_W-1:0]      o_ch,
    output ut_pkg::t_dec_stat            o_stat
);

    logic [23:0] r_gb, n_gb;
    logic [1:0]  r_gc, n_gc;
    logic [1:0]  r_exp, n_exp;
    logic [15:0] r_hs, n_hs;
    logic        r_sp, n_sp;

    logic [15:0] w_unit;
    logic        w_lo, w_hi;

    assign w_unit = (i_src == ut_pkg::ENC_UTF16BE) ? {r_gb[7:0], i_byte}
                                                   : {i_byte, r_gb[7:0]};
    assign w_hi = (w_unit >= ut_pkg::SUR_HI_MIN) && (w_unit <= ut_pkg::SUR_HI_MAX);
    assign w_lo = (w_unit >= ut_pkg::SUR_LO_MIN) && (w_unit <= ut_pkg::SUR_LO_MAX);

    always_comb begin
        n_gb   = r_gb;
        n_gc   = r_gc;
        n_exp  = r_exp;
        n_hs   = r_hs;
        n_sp   = r_sp;
        o_ch   = '0;
        o_emit = 1'b0;
        unique case (i_src) inside
            ut_pkg::ENC_ASCII: begin
                o_ch   = {25'd0, i_byte[6:0]};
                o_emit = 1'b1;
            end
            ut_pkg::ENC_LATIN1: begin
                o_ch   = {24'd0, i_byte};
                o_emit = 1'b1;
            end
            ut_pkg::ENC_UTF8: begin
                if (r_exp == 2'd0) begin
                    if ((i_byte & ut_pkg::UTF8_L2_MASK) == ut_pkg::UTF8_L2) begin
                        n_gb  = {16'd0, i_byte};
                        n_gc  = 2'd1;
                        n_exp = 2'd1;
                    end else if ((i_byte & ut_pkg::UTF8_L3_MASK) == ut_pkg::UTF8_L3) begin
                        n_gb  = {16'd0, i_byte};
                        n_gc  = 2'd1;
                        n_exp = 2'd2;
                    end else begin
                        o_ch   = {24'd0, i_byte};
                        o_emit = 1'b1;
                    end
                end else if (r_exp == 2'd1) begin
                    if (r_gc == 2'd1) begin
                        o_ch = {21'd0, r_gb[4:0], i_byte[5:0]};
                    end else begin
                        o_ch = {16'd0, r_gb[11:8], r_gb[5:0], i_byte[5:0]};
                    end
                    o_emit = 1'b1;
                    n_gb   = '0;
                    n_gc   = '0;
                    n_exp  = '0;
                end else begin
                    n_gb  = {r_gb[15:0], i_byte};
                    n_gc  = r_gc + 2'd1;
                    n_exp = r_exp - 2'd1;
                end
            end
            ut_pkg::ENC_UTF16BE, ut_pkg::ENC_UTF16LE, ut_pkg::ENC_UCS2: begin
                if (r_gc == 2'd0) begin
                    n_gb = {16'd0, i_byte};
                    n_gc = 2'd1;
                end else begin
                    n_gb   = '0;
                    n_gc   = '0;
                    n_exp  = '0;
                    o_emit = 1'b1;
                    if (i_src == ut_pkg::ENC_UCS2) begin
                        o_ch = {16'd0, w_unit};
                    end else if (r_sp) begin
                        if (w_lo) begin
                            o_ch = {12'd0, r_hs[9:0], w_unit[9:0]} + ut_pkg::CP_SUPP_BASE;
                        end else begin
                            o_ch = ut_pkg::CP_REPL;
                        end
                        n_sp = 1'b0;
                        n_hs = '0;
                    end else if (w_hi) begin
                        n_hs   = w_unit;
                        n_sp   = 1'b1;
                        o_emit = 1'b0;
                    end else if (w_lo) begin
                        o_ch = ut_pkg::CP_REPL;
                    end else begin
                        o_ch = {16'd0, w_unit};
                    end
                end
            end
            ut_pkg::ENC_UTF32BE, ut_pkg::ENC_UTF32LE, ut_pkg::ENC_UCS4: begin
                if (r_gc != 2'd3) begin
                    n_gb = {r_gb[15:0], i_byte};
                    n_gc = r_gc + 2'd1;
                end else begin
                    if (i_src == ut_pkg::ENC_UTF32BE) begin
                        o_ch = {r_gb, i_byte};
                    end else begin
                        o_ch = {i_byte, r_gb[7:0], r_gb[15:8], r_gb[23:16]};
                    end
                    o_emit = 1'b1;
                    n_gb   = '0;
                    n_gc   = '0;
                    n_exp  = '0;
                end
            end
            default: begin
            end
        endcase

        // end of stream drops partial units; a dangling high surrogate becomes U+FFFD
        if (i_eos) begin
            n_gb  = '0;
            n_gc  = '0;
            n_exp = '0;
            if (n_sp) begin
                n_sp   = 1'b0;
                n_hs   = '0;
                o_ch   = ut_pkg::CP_REPL;
                o_emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_gb  <= '0;
            r_gc  <= '0;
            r_exp <= '0;
            r_hs  <= '0;
            r_sp  <= 1'b0;
        end else if (i_fire) begin
            r_gb  <= n_gb;
            r_gc  <= n_gc;
            r_exp <= n_exp;
            r_hs  <= n_hs;
            r_sp  <= n_sp;
        end
    end

    assign o_stat.sur_pending = r_sp;
    assign o_stat.utf8_busy   = (r_exp != 2'd0);

endmodule

>>> rtl/core/ut_encode.sv
// Target side: maps one code point to up to four bytes, first byte in [7:0].
// Depends on ut_pkg.
module ut_encode (
    input  logic [ut_pkg::CP_W-1:0]  i_ch,
    input  logic [ut_pkg::CFG_W-1:0] i_tgt,
    output logic [31:0]              o_bytes,
    output logic [2:0]               o_cnt
);

    logic [ut_pkg::CP_W-1:0] w_ch;
    logic [19:0]             w_v;
    logic [15:0]             w_hi, w_lo, w_u2;

    // 16-bit unit in wire order, first byte low
    function automatic logic [15:0] put16(input logic [15:0] w, input logic le);
        put16 = le ? w : {w[7:0], w[15:8]};
    endfunction

    always_comb begin
        w_ch = i_ch;
        if (i_tgt >= ut_pkg::ENC_UTF8 && i_tgt <= ut_pkg::ENC_UTF32LE
                && i_ch > ut_pkg::CP_MAX) begin
            w_ch = ut_pkg::CP_REPL;
        end
    end

    assign w_v  = w_ch[19:0] - ut_pkg::CP_SUPP_BASE[19:0];
    assign w_hi = ut_pkg::SUR_HI_MIN | {6'd0, w_v[19:10]};
    assign w_lo = ut_pkg::SUR_LO_MIN | {6'd0, w_v[9:0]};
    assign w_u2 = (w_ch > ut_pkg::CP_BMP_MAX) ? ut_pkg::CP_REPL[15:0] : w_ch[15:0];

    always_comb begin
        o_bytes = '0;
        o_cnt   = 3'd0;
        unique case (i_tgt) inside
            ut_pkg::ENC_ASCII: begin
                o_bytes[7:0] = (w_ch <= 32'h7F) ? w_ch[7:0] : ut_pkg::ASCII_QMARK;
                o_cnt        = 3'd1;
            end
            ut_pkg::ENC_LATIN1: begin
                o_bytes[7:0] = w_ch[7:0];
                o_cnt        = 3'd1;
            end
            ut_pkg::ENC_UTF8: begin
                if (w_ch <= 32'h7F) begin
                    o_bytes[7:0] = w_ch[7:0];
                    o_cnt        = 3'd1;
                end else if (w_ch <= 32'h7FF) begin
                    o_bytes[15:0] = {{2'b10, w_ch[5:0]}, {3'b110, w_ch[10:6]}};
                    o_cnt         = 3'd2;
                end else if (w_ch <= ut_pkg::CP_BMP_MAX) begin
                    o_bytes[23:0] = {{2'b10, w_ch[5:0]}, {2'b10, w_ch[11:6]},
                                     {4'b1110, w_ch[15:12]}};
                    o_cnt         = 3'd3;
                end else begin
                    o_bytes = {{2'b10, w_ch[5:0]}, {2'b10, w_ch[11:6]},
                               {2'b10, w_ch[17:12]}, {5'b11110, w_ch[20:18]}};
                    o_cnt   = 3'd4;
                end
            end
            ut_pkg::ENC_UTF16BE, ut_pkg::ENC_UTF16LE: begin
                if (w_ch <= ut_pkg::CP_BMP_MAX) begin
                    o_bytes[15:0] = put16(w_ch[15:0], i_tgt == ut_pkg::ENC_UTF16LE);
                    o_cnt         = 3'd2;
                end else begin
                    o_bytes = {put16(w_lo, i_tgt == ut_pkg::ENC_UTF16LE),
                               put16(w_hi, i_tgt == ut_pkg::ENC_UTF16LE)};
                    o_cnt   = 3'd4;
                end
            end
            ut_pkg::ENC_UTF32BE: begin
                o_bytes = {put16(w_ch[15:0], 1'b0), put16(w_ch[31:16], 1'b0)};
                o_cnt   = 3'd4;
            end
            ut_pkg::ENC_UTF32LE: begin
                o_bytes = w_ch;
                o_cnt   = 3'd4;
            end
            ut_pkg::ENC_UCS2: begin
                o_bytes[15:0] = w_u2;
                o_cnt         = 3'd2;
            end
            ut_pkg::ENC_UCS4: begin
                o_bytes = (w_ch > ut_pkg::CP_UCS4_MAX) ? ut_pkg::CP_REPL : w_ch;
                o_cnt   = 3'd4;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/ut_serial.sv
// Result register: holds up to four encoded bytes and shifts them out a byte at a time.
// Depends on ut_out_if.
module ut_serial (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_bytes,
    input  logic [2:0]  i_cnt,
    output logic        o_can_load,
    ut_out_if.source    o_out
);

    logic [31:0] r_data;
    logic [2:0]  r_left;
    logic        w_take;

    assign w_take     = o_out.valid && o_out.ready;
    // free now, or its last byte leaves this cycle
    assign o_can_load = (r_left == 3'd0) || ((r_left == 3'd1) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_cnt;
        end else if (w_take) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_bytes;
        end else if (w_take) begin
            r_data <= {8'd0, r_data[31:8]};
        end
    end

    assign o_out.valid     = (r_left != 3'd0);
    assign o_out.out_byte  = r_data[7:0];
    assign o_out.char_done = (r_left == 3'd1);

endmodule

>>> rtl/core/unicode_transcoder_top.sv
// Unicode transcoder: one source byte in, zero to four target bytes out.
// Latency: first result byte is valid the cycle after its input byte is taken.
// Throughput: one input byte per cycle while each yields at most one byte and
// the output is ready; the one-byte shifter holds input till its last byte leaves.
// Reset (sync, active low): source ASCII, target UTF-16LE, assembly state clear.
// Depends on ut_pkg, ut_in_if, ut_out_if, ut_decode, ut_encode, ut_serial.
module unicode_transcoder_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [ut_pkg::CFG_W-1:0] i_cfg_data,
    ut_in_if.sink                    i_in,
    ut_out_if.source                 o_out
);

    logic [ut_pkg::CFG_W-1:0] r_src, r_tgt;
    logic                     w_fire, w_clr, w_emit, w_can_load, w_load;
    logic [ut_pkg::CP_W-1:0]  w_ch;
    logic [31:0]              w_bytes;
    logic [2:0]               w_cnt;
    ut_pkg::t_dec_stat        w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= ut_pkg::ENC_ASCII;
            r_tgt <= ut_pkg::ENC_UTF16LE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ut_pkg::CFG_SRC) begin
                r_src <= i_cfg_data;
            end else begin
                r_tgt <= i_cfg_data;
            end
        end
    end

    assign w_clr    = i_cfg_we && (i_cfg_idx == ut_pkg::CFG_SRC);
    assign i_in.ready = w_can_load;
    assign w_fire   = i_in.valid && w_can_load;
    assign w_load   = w_fire && w_emit && (w_cnt != 3'd0);

    ut_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_clr   (w_clr),
        .i_src   (r_src),
        .i_byte  (i_in.in_byte),
        .i_eos   (i_in.end_of_stream),
        .o_emit  (w_emit),
        .o_ch    (w_ch),
        .o_stat  (w_stat)
    );

    ut_encode u_encode (
        .i_ch    (w_ch),
        .i_tgt   (r_tgt),
        .o_bytes (w_bytes),
        .o_cnt   (w_cnt)
    );

    ut_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_bytes    (w_bytes),
        .i_cnt      (w_cnt),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out.valid)
        else $error("loaded character not presented");

    a_sur_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.sur_pending |-> (r_src == ut_pkg::ENC_UTF16BE ||
                                r_src == ut_pkg::ENC_UTF16LE))
        else $error("surrogate held outside UTF-16 source");

    a_utf8_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.utf8_busy |-> (r_src == ut_pkg::ENC_UTF8))
        else $error("UTF-8 sequence open outside UTF-8 source");

endmodule
